### rtl/sirs_grid_generation_step_assert.svh
// assertion macros for the sirs grid generation step
`ifndef SIRS_GRID_GENERATION_STEP_ASSERT_SVH
`define SIRS_GRID_GENERATION_STEP_ASSERT_SVH

// condition holds in the same cycle
`define SGS_ASSERT_HOLDS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sgs check failed: same-cycle invariant");

// condition holds in the following cycle
`define SGS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sgs check failed: next-cycle invariant");

`endif

### rtl/sgs_pkg.sv
// shared types and constants for the sirs grid generation step
`timescale 1ns / 1ps

package sgs_pkg;

    localparam int STATE_W       = 4;
    localparam int GRID_W_BITS   = 7;
    localparam int CLASS_W       = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 7;
    localparam int MAX_WIDTH_DEF = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_INFECTIOUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH = 2'd2;

    localparam logic [STATE_W-1:0]     INFECTIOUS_RST = 4'd4;
    localparam logic [STATE_W-1:0]     CYCLE_RST      = 4'd13;
    localparam logic [GRID_W_BITS-1:0] GRID_WIDTH_RST = 7'd40;

    localparam logic [CLASS_W-1:0] CLS_SUSCEPTIBLE = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_INFECTED    = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_RECOVERED   = 2'd2;

    // broadcast control for the row of column cells
    typedef struct packed {
        logic               shift;
        logic               load;
        logic               mid_we;
        logic               up_we;
        logic [STATE_W-1:0] mid_data;
        logic [STATE_W-1:0] up_data;
    } t_row_ctl;

    // a cell and its four neighbours, with flags for whether the upper, left and right ones exist
    typedef struct packed {
        logic [STATE_W-1:0] centre;
        logic [STATE_W-1:0] up;
        logic [STATE_W-1:0] left;
        logic [STATE_W-1:0] right;
        logic [STATE_W-1:0] low;
        logic               up_ok;
        logic               left_ok;
        logic               right_ok;
    } t_hood;

endpackage

### rtl/sgs_cell.sv
// one column cell: home copy of both row stores plus a working slot
`timescale 1ns / 1ps

module sgs_cell
    import sgs_pkg::*;
(
    input  logic               i_clk,
    input  t_row_ctl           i_ctl,
    input  logic               i_sel,
    input  logic [STATE_W-1:0] i_next_mid,
    input  logic [STATE_W-1:0] i_next_up,
    output logic [STATE_W-1:0] o_work_mid,
    output logic [STATE_W-1:0] o_work_up
);

    logic [STATE_W-1:0] r_home_mid;
    logic [STATE_W-1:0] r_home_up;
    logic [STATE_W-1:0] r_work_mid;
    logic [STATE_W-1:0] r_work_up;
    logic               mid_hit;
    logic               up_hit;

    assign mid_hit = i_sel && i_ctl.mid_we;
    assign up_hit  = i_sel && i_ctl.up_we;

    always_ff @(posedge i_clk) begin
        if (mid_hit) begin
            r_home_mid <= i_ctl.mid_data;
        end
        if (up_hit) begin
            r_home_up <= i_ctl.up_data;
        end
    end

    // working slot realigns to its own column at row end, else moves down the row
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_work_mid <= mid_hit ? i_ctl.mid_data : r_home_mid;
            r_work_up  <= up_hit ? i_ctl.up_data : r_home_up;
        end else if (i_ctl.shift) begin
            r_work_mid <= i_next_mid;
            r_work_up  <= i_next_up;
        end
    end

    assign o_work_mid = r_work_mid;
    assign o_work_up  = r_work_up;

endmodule

### rtl/sgs_chain.sv
// row of column cells holding the upper and middle line stores
`timescale 1ns / 1ps

module sgs_chain
    import sgs_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  t_row_ctl                     i_ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_col,
    output logic [STATE_W-1:0]           o_head_mid,
    output logic [STATE_W-1:0]           o_second_mid,
    output logic [STATE_W-1:0]           o_head_up
);

    localparam int CNT_W = $clog2(MAX_WIDTH);

    logic [STATE_W-1:0] link_mid [MAX_WIDTH+1];
    logic [STATE_W-1:0] link_up  [MAX_WIDTH+1];

    assign link_mid[MAX_WIDTH] = '0;
    assign link_up[MAX_WIDTH]  = '0;

    for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
        sgs_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (i_ctl),
            .i_sel      (i_col == CNT_W'(k)),
            .i_next_mid (link_mid[k+1]),
            .i_next_up  (link_up[k+1]),
            .o_work_mid (link_mid[k]),
            .o_work_up  (link_up[k])
        );
    end

    assign o_head_mid   = link_mid[0];
    assign o_second_mid = link_mid[1];
    assign o_head_up    = link_up[0];

endmodule

### rtl/sgs_rule.sv
// sirs update rule and health class of the new state
`timescale 1ns / 1ps

module sgs_rule
    import sgs_pkg::*;
(
    input  t_hood              i_hood,
    input  logic [STATE_W-1:0] i_infectious,
    input  logic [STATE_W-1:0] i_cycle,
    output logic [STATE_W-1:0] o_next_state,
    output logic [CLASS_W-1:0] o_health_class
);

    function automatic logic infected(input logic [STATE_W-1:0] s,
                                      input logic [STATE_W-1:0] period);
        return (s != '0) && (s <= period);
    endfunction

    logic               any_inf;
    logic [STATE_W-1:0] ns;

    assign any_inf = (i_hood.up_ok && infected(i_hood.up, i_infectious))
                   || (i_hood.left_ok && infected(i_hood.left, i_infectious))
                   || (i_hood.right_ok && infected(i_hood.right, i_infectious))
                   || infected(i_hood.low, i_infectious);

    always_comb begin
        if (i_hood.centre >= i_cycle) begin
            ns = '0;
        end else if (i_hood.centre == '0) begin
            ns = any_inf ? STATE_W'(1) : '0;
        end else begin
            ns = i_hood.centre + STATE_W'(1);
        end
    end

    always_comb begin
        if (ns == '0) begin
            o_health_class = CLS_SUSCEPTIBLE;
        end else if (infected(ns, i_infectious)) begin
            o_health_class = CLS_INFECTED;
        end else begin
            o_health_class = CLS_RECOVERED;
        end
    end

    assign o_next_state = ns;

endmodule

### rtl/sirs_grid_generation_step.sv
// top level: one sirs automaton generation over a raster cell stream
// input channel: i_in_valid / o_in_ready carry one cell item (state, beyond_edge flag)
//   per accepted item, in raster order; a closing row of beyond_edge items ends the frame
// output channel: o_out_valid / i_out_ready carry the new state of the cell one row
//   above the accepted item, its health class and a last-of-frame flag
// config channel: i_cfg_valid / o_cfg_ready with register index and data, always ready;
//   write only while no item is in flight
// throughput: one item per clock, limited by the row of column cells which read and
//   shift both line stores in a single cycle
// latency: a result is registered on the clock edge that accepts the item below it
//   and is offered on the next cycle; items of the first grid row give no result
// stall: a single output register; a new item is taken while the held result is
//   taken in the same cycle, otherwise the input waits
// reset: synchronous, active low; registers return to period 4, cycle 13, width 40,
//   column zero and awaiting the first row; line stores hold no defined data until the
//   first row has been written, and no clearing pass is needed
`timescale 1ns / 1ps
`include "sirs_grid_generation_step_assert.svh"

module sirs_grid_generation_step
    import sgs_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [STATE_W-1:0]    i_cell_state,
    input  logic                  i_beyond_edge,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [STATE_W-1:0]    o_next_state,
    output logic [CLASS_W-1:0]    o_health_class,
    output logic                  o_frame_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = (CNT_W + 1 > GRID_W_BITS) ? CNT_W + 1 : GRID_W_BITS;

    // configuration
    logic [STATE_W-1:0]     r_infectious;
    logic [STATE_W-1:0]     r_cycle;
    logic [GRID_W_BITS-1:0] r_grid_width;

    // raster position and frame progress
    logic [CNT_W-1:0]       r_col;
    logic [CNT_W-1:0]       n_col;
    logic                   r_first_row;
    logic                   r_second_row;
    logic [STATE_W-1:0]     r_prev_s;

    // output register
    logic                   r_out_valid;
    logic [STATE_W-1:0]     r_next_state;
    logic [CLASS_W-1:0]     r_health_class;
    logic                   r_frame_last;

    logic                   in_acc;
    logic                   skip;
    logic                   take;
    logic                   produce;
    logic [CMP_W-1:0]       gw_ext;
    logic [CMP_W-1:0]       used_w;
    logic                   row_end;
    logic [STATE_W-1:0]     low_val;
    logic [STATE_W-1:0]     head_mid;
    logic [STATE_W-1:0]     second_mid;
    logic [STATE_W-1:0]     head_up;
    t_row_ctl               ctl;
    t_hood                  hood;
    logic [STATE_W-1:0]     rule_state;
    logic [CLASS_W-1:0]     rule_class;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;

    // padding while still awaiting the first row is dropped without trace
    assign skip    = r_first_row && i_beyond_edge;
    assign take    = in_acc && !skip;
    assign produce = in_acc && !r_first_row;

    // width in use: zero acts as one, anything past the store depth as full depth
    assign gw_ext = CMP_W'(r_grid_width);
    always_comb begin
        if (gw_ext == '0) begin
            used_w = CMP_W'(1);
        end else if (gw_ext > CMP_W'(MAX_WIDTH)) begin
            used_w = CMP_W'(MAX_WIDTH);
        end else begin
            used_w = gw_ext;
        end
    end

    assign row_end = (CMP_W'(r_col) + CMP_W'(1)) >= used_w;
    assign n_col   = row_end ? '0 : r_col + CNT_W'(1);

    // padding inside a row is a susceptible lower neighbour and is stored as zero
    assign low_val = i_beyond_edge ? '0 : i_cell_state;

    // line stores: middle takes the new item, upper takes the old middle cell
    always_comb begin
        ctl.shift    = take && !row_end;
        ctl.load     = take && row_end;
        ctl.mid_we   = take;
        ctl.up_we    = produce;
        ctl.mid_data = low_val;
        ctl.up_data  = head_mid;
    end

    sgs_chain #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_chain (
        .i_clk        (i_clk),
        .i_ctl        (ctl),
        .i_col        (r_col),
        .o_head_mid   (head_mid),
        .o_second_mid (second_mid),
        .o_head_up    (head_up)
    );

    // left neighbour is the middle cell handled one item earlier in this row
    always_comb begin
        hood.centre   = head_mid;
        hood.up       = head_up;
        hood.left     = r_prev_s;
        hood.right    = second_mid;
        hood.low      = low_val;
        hood.up_ok    = !r_second_row;
        hood.left_ok  = r_col != '0;
        hood.right_ok = !row_end;
    end

    sgs_rule u_rule (
        .i_hood         (hood),
        .i_infectious   (r_infectious),
        .i_cycle        (r_cycle),
        .o_next_state   (rule_state),
        .o_health_class (rule_class)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_infectious <= INFECTIOUS_RST;
            r_cycle      <= CYCLE_RST;
            r_grid_width <= GRID_WIDTH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_INFECTIOUS: r_infectious <= i_cfg_data[STATE_W-1:0];
                CFG_CYCLE:      r_cycle      <= i_cfg_data[STATE_W-1:0];
                CFG_GRID_WIDTH: r_grid_width <= i_cfg_data[GRID_W_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // column counter and row flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_first_row  <= 1'b1;
            r_second_row <= 1'b1;
        end else if (take) begin
            r_col <= n_col;
            if (row_end) begin
                if (r_first_row) begin
                    r_first_row <= 1'b0;
                end else if (i_beyond_edge) begin
                    // flush row closed: back to awaiting a new frame
                    r_first_row  <= 1'b1;
                    r_second_row <= 1'b1;
                end else begin
                    r_second_row <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_prev_s <= head_mid;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (produce) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_next_state   <= rule_state;
            r_health_class <= rule_class;
            r_frame_last   <= row_end && i_beyond_edge;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_next_state   = r_next_state;
    assign o_health_class = r_health_class;
    assign o_frame_last   = r_frame_last;

    // checks
    `SGS_ASSERT_HOLDS(a_first_implies_second, r_first_row, r_second_row)
    `SGS_ASSERT_HOLDS(a_class_zero_iff_zero, o_out_valid, ((o_next_state == '0) == (o_health_class == CLS_SUSCEPTIBLE)))
    `SGS_ASSERT_NEXT(a_frame_end_rearms, produce && row_end && i_beyond_edge, r_first_row && r_second_row && r_col == '0)

endmodule

### verif/sirs_grid_generation_step_test.sv
// testbench: raster cell streams into the sirs grid generation step, checked by a built-in predictor
`timescale 1ns / 1ps

module sirs_grid_generation_step_test;
    import sgs_pkg::*;

    localparam int MAX_W         = MAX_WIDTH_DEF;
    localparam int ITEM_TARGET   = 1750;
    // run limit in cycles, meant to stay well above what the slowest run needs
    localparam int CYCLE_LIMIT   = 500000;
    // items of the first row give no result, so let the block settle after the last one
    localparam int SETTLE_CYCLES = 6;

    // one cell item as it goes over the input channel
    typedef struct {
        logic [STATE_W-1:0] state;
        logic               pad;
    } t_cell_item;

    // one new cell state as it comes back
    typedef struct {
        logic [STATE_W-1:0] next_state;
        logic [CLASS_W-1:0] health;
        logic               last;
    } t_cell_update;

    logic                   i_clk;
    logic                   i_rst_n        = 1'b0;
    logic                   i_in_valid     = 1'b0;
    logic                   o_in_ready;
    logic [STATE_W-1:0]     i_cell_state   = '0;
    logic                   i_beyond_edge  = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_ready    = 1'b0;
    logic [STATE_W-1:0]     o_next_state;
    logic [CLASS_W-1:0]     o_health_class;
    logic                   o_frame_last;
    logic                   i_cfg_valid    = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data     = '0;

    // predictor copy of the registers and of the line stores
    logic [STATE_W-1:0]     period_q       = INFECTIOUS_RST;
    logic [STATE_W-1:0]     cycle_q        = CYCLE_RST;
    logic [GRID_W_BITS-1:0] width_q        = GRID_WIDTH_RST;
    logic [STATE_W-1:0]     upper_cells  [MAX_W] = '{default: '0};
    logic [STATE_W-1:0]     middle_cells [MAX_W] = '{default: '0};
    int                     column_q       = 0;
    bit                     first_row_q    = 1'b1;
    bit                     second_row_q   = 1'b1;

    t_cell_item             cells_to_send   [$];
    t_cell_update           awaited_updates [$];

    int cells_queued = 0;
    int mismatches   = 0;
    int cycle_count  = 0;
    int burst_left   = 0;
    int gap_left     = 0;
    int stall_count  = 0;
    int stall_mode   = 0;

    sirs_grid_generation_step #(
        .MAX_WIDTH(MAX_W)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cell_state  (i_cell_state),
        .i_beyond_edge (i_beyond_edge),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_next_state  (o_next_state),
        .o_health_class(o_health_class),
        .o_frame_last  (o_frame_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic bit infected(logic [STATE_W-1:0] s);
        return (s != 0) && (s <= period_q);
    endfunction

    // width 0 behaves as one column, anything past the stores as full stores
    function automatic int width_in_use();
        if (width_q == 0) return 1;
        if (width_q > MAX_W) return MAX_W;
        return int'(width_q);
    endfunction

    // takes one accepted item, returns 1 with the update it causes, if any
    function automatic bit advance_cell(input t_cell_item it, output t_cell_update upd);
        int                 w;
        int                 c;
        bit                 row_end;
        bit                 exposed;
        logic [STATE_W-1:0] s;
        logic [STATE_W-1:0] ns;
        w = width_in_use();
        c = column_q;
        if (c >= MAX_W) c = MAX_W - 1;
        // a row closes once the column reaches the width in force now
        row_end = (c + 1 >= w);
        upd = '{next_state: '0, health: CLS_SUSCEPTIBLE, last: 1'b0};

        // first row only fills the middle store, stray padding is dropped
        if (first_row_q) begin
            if (it.pad) return 1'b0;
            middle_cells[c] = it.state;
            if (row_end) begin
                column_q    = 0;
                first_row_q = 1'b0;
            end else begin
                column_q = c + 1;
            end
            return 1'b0;
        end

        s       = middle_cells[c];
        exposed = 1'b0;
        // cell above only exists from the third row of items on
        if (!second_row_q && infected(upper_cells[c])) exposed = 1'b1;
        // left neighbour was already moved up this row
        if (c > 0 && infected(upper_cells[c - 1])) exposed = 1'b1;
        if (c + 1 < w && infected(middle_cells[c + 1])) exposed = 1'b1;
        // padding counts as a healthy lower neighbour
        if (!it.pad && infected(it.state)) exposed = 1'b1;

        // at or past the cycle length a cell recovers fully, including saturation
        if (s >= cycle_q) ns = '0;
        else if (s == '0) ns = exposed ? STATE_W'(1) : '0;
        else ns = s + 1'b1;

        upd.next_state = ns;
        if (ns == 0) upd.health = CLS_SUSCEPTIBLE;
        else if (infected(ns)) upd.health = CLS_INFECTED;
        else upd.health = CLS_RECOVERED;

        upper_cells[c]  = s;
        middle_cells[c] = it.pad ? '0 : it.state;

        if (row_end) begin
            column_q     = 0;
            second_row_q = 1'b0;
            // a padded row end closes the generation
            if (it.pad) begin
                upd.last     = 1'b1;
                first_row_q  = 1'b1;
                second_row_q = 1'b1;
            end
        end else begin
            column_q = c + 1;
        end
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic void push_cell(int s, bit p, bit counted);
        cells_to_send.push_back('{state: STATE_W'(s), pad: p});
        if (counted) cells_queued++;
    endfunction

    // mostly healthy, infected and recovering cells of the current settings
    function automatic logic [STATE_W-1:0] pick_state();
        int                 p;
        int                 q;
        logic [STATE_W-1:0] s;
        p = int'(period_q);
        q = int'(cycle_q);
        case ($urandom_range(9))
            0, 1, 2: s = '0;
            3, 4, 5: s = (p == 0) ? STATE_W'($urandom_range(15))
                                  : STATE_W'($urandom_range(p, 1));
            6, 7, 8: s = (q > p + 1) ? STATE_W'($urandom_range(q, p + 1))
                                     : STATE_W'($urandom_range(15));
            default: s = STATE_W'($urandom_range(15));
        endcase
        return s;
    endfunction

    // one whole generation of the given height, closed by a flush row
    function automatic void queue_generation(int rows, bit noisy);
        int w;
        w = width_in_use();
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < w; c++) begin
                // stray padding in the first row, to be skipped
                if (noisy && r == 0 && $urandom_range(15) == 0)
                    push_cell($urandom_range(15), 1'b1, 1'b0);
                // padding inside a later row stands for a zero cell
                if (noisy && r > 0 && $urandom_range(19) == 0)
                    push_cell($urandom_range(15), 1'b1, 1'b1);
                else
                    push_cell(int'(pick_state()), 1'b0, 1'b1);
            end
        end
        // flush row: only its closing item has to be padding
        for (int c = 0; c < w; c++)
            push_cell($urandom_range(15),
                      (c == w - 1) || !noisy || ($urandom_range(7) != 0), 1'b1);
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_INFECTIOUS: period_q = data[STATE_W-1:0];
            CFG_CYCLE:      cycle_q  = data[STATE_W-1:0];
            CFG_GRID_WIDTH: width_q  = data[GRID_W_BITS-1:0];
            default: ;
        endcase
    endtask

    // block idle: nothing queued, nothing offered, no update outstanding
    task automatic wait_idle();
        do @(negedge i_clk);
        while (cells_to_send.size() != 0 || i_in_valid || awaited_updates.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic void note_mismatch(string field, int want, int got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    // ---------------------------------------------------------------- sender

    // bursts of random length, gaps between them, now and then a long run with no gaps
    always @(posedge i_clk) begin : cell_sender
        t_cell_item nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (cells_to_send.size() != 0) begin
                nxt = cells_to_send.pop_front();
                i_in_valid    <= 1'b1;
                i_cell_state  <= nxt.state;
                i_beyond_edge <= nxt.pad;
                if (burst_left > 0) begin
                    burst_left--;
                end else if ($urandom_range(3) == 0) begin
                    burst_left = $urandom_range(80, 30);
                    gap_left   = 0;
                end else begin
                    burst_left = $urandom_range(12);
                    gap_left   = $urandom_range(6, 1);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    // stall pattern changes every so often: always ready, light, periodic, heavy
    always @(posedge i_clk) begin : update_receiver
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            stall_count++;
            if (stall_count % 97 == 0) stall_mode = $urandom_range(3);
            case (stall_mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= ($urandom_range(3) != 0);
                2:       i_out_ready <= (stall_count % 5 < 2);
                default: i_out_ready <= ($urandom_range(7) == 0);
            endcase
        end
    end

    // ---------------------------------------------------------------- monitor

    // update check first, then prediction for the item taken at the same edge;
    // an update can never belong to the item accepted on its own edge
    always @(posedge i_clk) begin : update_monitor
        t_cell_update want;
        t_cell_item   taken;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (awaited_updates.size() == 0) begin
                    mismatches++;
                    $display("%0t: update with none awaited, expected none, got state %0d",
                             $time, o_next_state);
                end else begin
                    want = awaited_updates.pop_front();
                    if (o_next_state !== want.next_state)
                        note_mismatch("next_state", want.next_state, o_next_state);
                    if (o_health_class !== want.health)
                        note_mismatch("health_class", want.health, o_health_class);
                    if (o_frame_last !== want.last)
                        note_mismatch("frame_last", want.last, o_frame_last);
                end
            end
            if (i_in_valid && o_in_ready) begin
                taken.state = i_cell_state;
                taken.pad   = i_beyond_edge;
                if (advance_cell(taken, want)) awaited_updates.push_back(want);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- test sequence

    initial begin : stimulus
        int                     phase;
        int                     p;
        int                     q;
        int                     rows;
        logic [GRID_W_BITS-1:0] gw;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset period and cycle, three columns: stray padding in the first row,
        // a saturated cell, padding mid-row and a flush row that is not all padding
        write_register(CFG_GRID_WIDTH, 7'd3);
        @(negedge i_clk);
        push_cell(0, 1'b0, 1'b1);
        push_cell(9, 1'b1, 1'b0);
        push_cell(4, 1'b0, 1'b1);
        push_cell(13, 1'b0, 1'b1);
        push_cell(15, 1'b0, 1'b1);
        push_cell(0, 1'b0, 1'b1);
        push_cell(5, 1'b0, 1'b1);
        push_cell(6, 1'b1, 1'b1);
        push_cell(7, 1'b0, 1'b1);
        push_cell(15, 1'b1, 1'b1);
        wait_idle();

        // width 0 acts as a single column, nothing infected, cycle length 1
        write_register(CFG_INFECTIOUS, 7'd0);
        write_register(CFG_CYCLE, 7'd1);
        write_register(CFG_GRID_WIDTH, 7'd0);
        @(negedge i_clk);
        push_cell(1, 1'b0, 1'b1);
        push_cell(0, 1'b0, 1'b1);
        push_cell(0, 1'b1, 1'b1);
        wait_idle();

        // cycle not above period, then the width shrinks part way through a row
        write_register(CFG_INFECTIOUS, 7'd14);
        write_register(CFG_CYCLE, 7'd2);
        write_register(CFG_GRID_WIDTH, 7'd4);
        @(negedge i_clk);
        push_cell(2, 1'b0, 1'b1);
        push_cell(1, 1'b0, 1'b1);
        push_cell(0, 1'b0, 1'b1);
        push_cell(14, 1'b0, 1'b1);
        push_cell(0, 1'b0, 1'b1);
        push_cell(1, 1'b0, 1'b1);
        wait_idle();
        write_register(CFG_INFECTIOUS, 7'd1);
        write_register(CFG_CYCLE, 7'd15);
        write_register(CFG_GRID_WIDTH, 7'd2);
        @(negedge i_clk);
        push_cell(5, 1'b0, 1'b1);
        push_cell(0, 1'b0, 1'b1);
        push_cell(1, 1'b0, 1'b1);
        push_cell(3, 1'b1, 1'b1);
        push_cell(8, 1'b1, 1'b1);
        wait_idle();

        // random phases; settings change only between whole generations,
        // first two phases take the widest grids
        phase = 0;
        while (cells_queued < ITEM_TARGET) begin
            p = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(14, 1);
            q = ($urandom_range(9) == 0) ? $urandom_range(15)
                                         : $urandom_range(15, (p < 14) ? p + 1 : 15);
            case ($urandom_range(9))
                0:       gw = '0;
                1:       gw = GRID_W_BITS'($urandom_range(64, 33));
                2:       gw = GRID_W_BITS'($urandom_range(127, 65));
                default: gw = GRID_W_BITS'($urandom_range(12, 1));
            endcase
            if (phase == 0) gw = GRID_W_BITS'(127);
            if (phase == 1) gw = GRID_W_BITS'(MAX_W);
            // unused upper data bits of the state registers carry junk
            if (phase < 2 || $urandom_range(4) != 0)
                write_register(CFG_INFECTIOUS, CFG_DATA_W'(16 * $urandom_range(7) + p));
            if (phase < 2 || $urandom_range(4) != 0)
                write_register(CFG_CYCLE, CFG_DATA_W'(16 * $urandom_range(7) + q));
            if (phase < 2 || $urandom_range(4) != 0)
                write_register(CFG_GRID_WIDTH, gw);
            @(negedge i_clk);
            repeat ($urandom_range(3, 1)) begin
                rows = (width_in_use() > 16) ? $urandom_range(2, 1) : $urandom_range(6, 1);
                queue_generation(rows, $urandom_range(2) == 0);
            end
            // stimulus holds off here until every update has come back
            wait_idle();
            phase++;
        end

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
